### rtl/assert_macros.svh
// Assertion macros included by xyz_to_lab_converter.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while rst is high.
`define XTL_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// Implication checked in the next cycle, active during reset as well.
`define XTL_ASSERT_NEXT(label, clk, a, c) \
   label: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("assertion failed");

`endif

### rtl/xtl_pkg.sv
package xtl_pkg;

   localparam int unsigned COMP_W    = 16;
   localparam int unsigned DIV_BITS  = 64;
   localparam int unsigned FRAC_BITS = 48;
   localparam int unsigned ROOT_BITS = 22;
   localparam int unsigned F_W       = 22;
   localparam int unsigned N_W       = 26;
   localparam int unsigned LIN_W     = 14;
   localparam int unsigned L_W       = 15;
   localparam int unsigned AB_W      = 16;

   localparam logic [COMP_W-1:0] WHITE_X_RESET = 16'd31145;
   localparam logic [COMP_W-1:0] WHITE_Y_RESET = 16'd32768;
   localparam logic [COMP_W-1:0] WHITE_Z_RESET = 16'd35678;

   // Ratio threshold (6/29)^3 in Q16.48.
   localparam logic [63:0] LIN_THR   = (64'd216 << 48) / 64'd24389;
   // Reciprocal of 3132 scaled by 2^40, rounded up; exact for 26-bit inputs.
   localparam int unsigned RECIP_SH  = 40;
   localparam logic [28:0] RECIP_M   = 29'(((64'd1 << 40) + 64'd3131) / 64'd3132);

   localparam int unsigned LATENCY   = DIV_BITS + ROOT_BITS + 2;

   localparam logic signed [33:0] L_MIN  = -34'sd2048;
   localparam logic signed [33:0] L_MAX  = 34'sd16383;
   localparam logic signed [33:0] AB_MIN = -34'sd32768;
   localparam logic signed [33:0] AB_MAX = 34'sd32767;

   typedef enum logic [1:0] {
      CSR_WHITE_X = 2'd0,
      CSR_WHITE_Y = 2'd1,
      CSR_WHITE_Z = 2'd2
   } csr_index_type;

endpackage

### rtl/xtl_lane.sv
module xtl_lane (
   input  logic                        clock,
   input  logic [xtl_pkg::COMP_W-1:0]  value,
   input  logic [xtl_pkg::COMP_W-1:0]  white,
   output logic [xtl_pkg::F_W-1:0]     f_out
);
   import xtl_pkg::*;

   typedef struct packed {
      logic [63:0]      x;
      logic [21:0]      y;
      logic [43:0]      y2;
      logic             sel;
      logic [N_W-1:0]   n;
      logic [LIN_W-1:0] lin;
   } root_type;

   logic [COMP_W-1:0] rem_ff [DIV_BITS];
   logic [63:0]       quo_ff [DIV_BITS];
   logic [COMP_W-1:0] val_ff [DIV_BITS];
   logic [COMP_W-1:0] wht_ff [DIV_BITS];
   root_type          root_ff [ROOT_BITS];

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      localparam int unsigned BitIdx = DIV_BITS - 1 - k;
      logic [COMP_W-1:0] rem_prev, val_prev, wht_prev, rem_in;
      logic [63:0]       quo_prev, quo_in;
      logic              num_bit, ge;
      logic [COMP_W:0]   cur;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign val_prev = value;
         assign wht_prev = (white == '0) ? COMP_W'(1) : white;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign val_prev = val_ff[k-1];
         assign wht_prev = wht_ff[k-1];
      end

      if (BitIdx >= FRAC_BITS) begin : g_vbit
         assign num_bit = val_prev[BitIdx-FRAC_BITS];
      end else begin : g_zbit
         assign num_bit = 1'b0;
      end

      always_comb begin
         cur    = {rem_prev, num_bit};
         ge     = cur >= {1'b0, wht_prev};
         rem_in = ge ? COMP_W'(cur - {1'b0, wht_prev}) : cur[COMP_W-1:0];
         quo_in = quo_prev;
         quo_in[BitIdx] = ge;
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         quo_ff[k] <= quo_in;
         val_ff[k] <= val_prev;
         wht_ff[k] <= wht_prev;
      end
   end

   // Bitwise integer cube root, three radicand bits per stage. The linear
   // segment is worked out in the first two stages and carried alongside.
   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      localparam int unsigned Shift = 3 * (ROOT_BITS - 1 - j);
      root_type    prev, nxt;
      logic [21:0] y1;
      logic [43:0] y2a;
      logic [47:0] bsum, bval;
      logic        ge;
      logic [57:0] prod;
      logic [63:0] lin_prod;

      if (j == 0) begin : g_first
         always_comb begin
            prev    = '0;
            prev.x  = quo_ff[DIV_BITS-1];
         end
      end else begin : g_next
         assign prev = root_ff[j-1];
      end

      always_comb begin
         y1       = {prev.y[20:0], 1'b0};
         y2a      = {prev.y2[41:0], 2'b00};
         bsum     = 48'(y2a) + 48'(y1);
         bval     = 48'(bsum * 48'd3) + 48'd1;
         ge       = (prev.x >> Shift) >= 64'(bval);
         prod     = 58'(prev.x[41:0]) * 58'd24389 + (58'd432 << 48);
         lin_prod = 64'(prev.n) * 64'(RECIP_M);
         nxt      = prev;
         if (ge) begin
            nxt.x  = prev.x - (64'(bval) << Shift);
            nxt.y  = y1 + 22'd1;
            nxt.y2 = y2a + 44'({y1, 1'b0}) + 44'd1;
         end else begin
            nxt.y  = y1;
            nxt.y2 = y2a;
         end
         if (j == 0) begin
            nxt.sel = prev.x > LIN_THR;
            nxt.n   = prod[57:32];
         end
         if (j == 1) begin
            nxt.lin = LIN_W'(lin_prod >> RECIP_SH);
         end
      end

      always_ff @(posedge clock) begin
         root_ff[j] <= nxt;
      end
   end

   assign f_out = root_ff[ROOT_BITS-1].sel ? root_ff[ROOT_BITS-1].y
                                           : F_W'(root_ff[ROOT_BITS-1].lin);

endmodule

### rtl/xtl_merge.sv
module xtl_merge (
   input  logic                           clock,
   input  logic [xtl_pkg::F_W-1:0]        fx,
   input  logic [xtl_pkg::F_W-1:0]        fy,
   input  logic [xtl_pkg::F_W-1:0]        fz,
   output logic signed [xtl_pkg::L_W-1:0]  lightness,
   output logic signed [xtl_pkg::AB_W-1:0] green_red,
   output logic signed [xtl_pkg::AB_W-1:0] blue_yellow
);
   import xtl_pkg::*;

   logic signed [33:0] l_ff, a_ff, b_ff, l_in, a_in, b_in;
   logic signed [L_W-1:0]  lo_ff;
   logic signed [AB_W-1:0] ao_ff, bo_ff;

   // Round half up to 6 fraction bits, then clamp.
   function automatic logic signed [33:0] round_sat(input logic signed [33:0] v,
                                                    input logic signed [33:0] lo,
                                                    input logic signed [33:0] hi);
      logic signed [33:0] w, q;
      w = v + 34'sd512;
      q = w >>> 10;
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      return q;
   endfunction

   always_comb begin
      l_in = 34'sd116 * $signed({12'b0, fy}) - 34'sd1048576;
      a_in = 34'sd500 * ($signed({12'b0, fx}) - $signed({12'b0, fy}));
      b_in = 34'sd200 * ($signed({12'b0, fy}) - $signed({12'b0, fz}));
   end

   always_ff @(posedge clock) begin
      l_ff  <= l_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
      lo_ff <= L_W'(round_sat(l_ff, L_MIN, L_MAX));
      ao_ff <= AB_W'(round_sat(a_ff, AB_MIN, AB_MAX));
      bo_ff <= AB_W'(round_sat(b_ff, AB_MIN, AB_MAX));
   end

   assign lightness   = lo_ff;
   assign green_red   = ao_ff;
   assign blue_yellow = bo_ff;

endmodule

### rtl/xyz_to_lab_converter.sv
// XYZ to CIELAB converter. One request is taken in every clock cycle while
// busy is low (busy is high only during reset), and its result appears on the
// rsp_ ports for a single cycle, marked by rsp_strobe, after it has passed
// through 64 stages of restoring ratio division, 22 stages of cube root and
// two stages that form and round L, a and b. The receiver cannot stall the
// block, so results must be taken as they appear. The user writes the reference white
// through the csr_ port only while no request is in flight; the block does not enforce it.
module xyz_to_lab_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [xtl_pkg::COMP_W-1:0]       req_x_value,
   input  logic [xtl_pkg::COMP_W-1:0]       req_y_value,
   input  logic [xtl_pkg::COMP_W-1:0]       req_z_value,
   output logic                             rsp_strobe,
   output logic signed [xtl_pkg::L_W-1:0]   rsp_lightness,
   output logic signed [xtl_pkg::AB_W-1:0]  rsp_green_red,
   output logic signed [xtl_pkg::AB_W-1:0]  rsp_blue_yellow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [xtl_pkg::COMP_W-1:0]       csr_data
);
   import xtl_pkg::*;
   `include "assert_macros.svh"

   logic [COMP_W-1:0] white_x_ff, white_y_ff, white_z_ff, csr_val;
   logic [LATENCY-1:0] vld_ff, vld_in;
   logic [F_W-1:0] fx, fy, fz;
   logic accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign csr_val   = (csr_data == '0) ? COMP_W'(1) : csr_data;
   assign vld_in    = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         white_x_ff <= WHITE_X_RESET;
         white_y_ff <= WHITE_Y_RESET;
         white_z_ff <= WHITE_Z_RESET;
         vld_ff     <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_WHITE_X: white_x_ff <= csr_val;
               CSR_WHITE_Y: white_y_ff <= csr_val;
               CSR_WHITE_Z: white_z_ff <= csr_val;
               default: ;
            endcase
         end
      end
   end

   xtl_lane u_lane_x (.clock(clock), .value(req_x_value), .white(white_x_ff), .f_out(fx));
   xtl_lane u_lane_y (.clock(clock), .value(req_y_value), .white(white_y_ff), .f_out(fy));
   xtl_lane u_lane_z (.clock(clock), .value(req_z_value), .white(white_z_ff), .f_out(fz));

   xtl_merge u_merge (
      .clock(clock), .fx(fx), .fy(fy), .fz(fz),
      .lightness(rsp_lightness), .green_red(rsp_green_red),
      .blue_yellow(rsp_blue_yellow)
   );

   assign rsp_strobe = vld_ff[LATENCY-1];

   `XTL_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_strobe)
   `XTL_ASSERT_IMP(a_latency, clock, reset, accept, ##LATENCY rsp_strobe)
   `XTL_ASSERT_IMP(a_l_range, clock, reset, rsp_strobe, rsp_lightness >= -15'sd2048)

endmodule
